### rtl/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and character functions of the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  localparam logic [6:0] CODE_PAD = 7'd64;
  localparam logic [6:0] CODE_BAD = 7'd65;
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last;
    logic            fin;
    logic            bad;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'(8'd65 + w);
    end else if (v < 6'd52) begin
      return 8'(8'd71 + w);
    end else if (v < 6'd62) begin
      return 8'(w - 8'd4);
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  function automatic logic [6:0] char_code(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      return 7'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      return 7'(c + 8'd4);
    end else if (c == 8'h2B) begin
      return 7'd62;
    end else if (c == 8'h2F) begin
      return 7'd63;
    end else if (c == PAD_CHAR) begin
      return CODE_PAD;
    end else begin
      return CODE_BAD;
    end
  endfunction

endpackage

### rtl/b64sc_front.sv
// ----------------------------------------------------------------------------
// b64sc_front
// Accepts items, collects groups and builds one output job per group.
// ----------------------------------------------------------------------------
module b64sc_front import b64sc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic      stream_end_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output job_t      job_o
);

  logic        mode_q;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  fill_q, fill_d;
  logic [1:0]  pad_q, pad_d;
  logic        accept;
  logic [1:0]  enc_fill;
  logic [1:0]  fill1;
  logic [23:0] merged;
  logic [6:0]  code;
  logic [23:0] dec_bits;
  logic [1:0]  pad_new;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign code       = char_code(data_byte_i);

  always_comb begin
    enc_fill = (fill_q == 2'd3) ? 2'd0 : fill_q;
    fill1    = 2'(enc_fill + 2'd1);
    case (enc_fill)
      2'd0:    merged = bits_q | {data_byte_i, 16'h0000};
      2'd1:    merged = bits_q | {8'h00, data_byte_i, 8'h00};
      default: merged = bits_q | {16'h0000, data_byte_i};
    endcase
    case (fill_q)
      2'd0:    dec_bits = bits_q | {code[5:0], 18'h0};
      2'd1:    dec_bits = bits_q | {6'h0, code[5:0], 12'h0};
      2'd2:    dec_bits = bits_q | {12'h0, code[5:0], 6'h0};
      default: dec_bits = bits_q | {18'h0, code[5:0]};
    endcase
    pad_new = 2'(pad_q + 2'd1);
  end

  always_comb begin
    bits_d = bits_q;
    fill_d = fill_q;
    pad_d  = pad_q;
    push_o = 1'b0;
    job_o  = '0;
    if (accept) begin
      if (!mode_q) begin
        if (fill1 < 2'd3 && !stream_end_i) begin
          bits_d = merged;
          fill_d = fill1;
        end else begin
          push_o       = 1'b1;
          job_o.last   = 2'd3;
          job_o.fin    = stream_end_i;
          for (int k = 0; k < 4; k++) begin
            job_o.bytes[k] = (k <= int'(fill1)) ? sextet_char(merged[23-6*k -: 6]) : PAD_CHAR;
          end
          bits_d = '0;
          fill_d = '0;
          pad_d  = '0;
        end
      end else begin
        if (code == CODE_BAD || (code == CODE_PAD && fill_q < 2'd2) ||
            (code != CODE_PAD && pad_q != 2'd0)) begin
          push_o    = 1'b1;
          job_o.fin = stream_end_i;
          job_o.bad = 1'b1;
          bits_d    = '0;
          fill_d    = '0;
          pad_d     = '0;
        end else if (fill_q == 2'd3) begin
          push_o         = 1'b1;
          job_o.bytes[0] = (code == CODE_PAD) ? bits_q[23:16] : dec_bits[23:16];
          job_o.bytes[1] = (code == CODE_PAD) ? bits_q[15:8] : dec_bits[15:8];
          job_o.bytes[2] = (code == CODE_PAD) ? bits_q[7:0] : dec_bits[7:0];
          if (code == CODE_PAD) begin
            job_o.last = (pad_new > 2'd2) ? 2'd0 : 2'(2'd2 - pad_new);
          end else begin
            job_o.last = 2'd2;
          end
          job_o.fin = stream_end_i;
          bits_d    = '0;
          fill_d    = '0;
          pad_d     = '0;
        end else if (stream_end_i) begin
          push_o    = 1'b1;
          job_o.fin = 1'b1;
          job_o.bad = 1'b1;
          bits_d    = '0;
          fill_d    = '0;
          pad_d     = '0;
        end else begin
          if (code == CODE_PAD) begin
            pad_d = pad_new;
          end else begin
            bits_d = dec_bits;
          end
          fill_d = 2'(fill_q + 2'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      bits_q <= '0;
      fill_q <= '0;
      pad_q  <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
      bits_q <= '0;
      fill_q <= '0;
      pad_q  <= '0;
    end else begin
      bits_q <= bits_d;
      fill_q <= fill_d;
      pad_q  <= pad_d;
    end
  end

endmodule

### rtl/b64sc_queue.sv
// ----------------------------------------------------------------------------
// b64sc_queue
// Short job queue between the group builder and the output sequencer.
// ----------------------------------------------------------------------------
module b64sc_queue import b64sc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      head_o,
  output q_status_t status_o
);

  job_t               entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q;

  assign status_o.full  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= Q_PTR_W'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= Q_PTR_W'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        count_q <= Q_CNT_W'(count_q + 1'b1);
      end else if (pop_i && !push_i) begin
        count_q <= Q_CNT_W'(count_q - 1'b1);
      end
    end
  end

endmodule

### rtl/b64sc_back.sv
// ----------------------------------------------------------------------------
// b64sc_back
// Steps through the head job and emits one result per cycle, unless the
// output stalls, into the output register.
// ----------------------------------------------------------------------------
module b64sc_back import b64sc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      head_i,
  input  q_status_t q_status_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic [7:0] out_byte_o,
  output logic      out_final_o,
  output logic      bad_input_o
);

  logic       valid_q;
  logic [1:0] idx_q;
  logic [7:0] byte_q;
  logic       fin_q;
  logic       bad_q;
  logic       load;

  assign load  = !q_status_i.empty && (!valid_q || !out_stall_i);
  assign pop_o = load && (idx_q == head_i.last);

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_final_o = fin_q;
  assign bad_input_o = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= (idx_q == head_i.last) ? 2'd0 : 2'(idx_q + 2'd1);
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      fin_q  <= head_i.fin && (idx_q == head_i.last);
      bad_q  <= head_i.bad;
    end
  end

endmodule

### rtl/base64_stream_codec_unit.sv
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// Base64 encoder/decoder with a mode register, group builder, job queue and
// output sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  cfg     | cfg_we_i                 | cfg_data_i (decode mode)
//  in      | in_valid_i / in_stall_o  | data_byte_i, stream_end_i
//  out     | out_valid_o / out_stall_i| out_byte_o, out_final_o, bad_input_o
//
//  An input item is taken while the two-entry job queue has room.
//  Results leave at one per cycle from the output register while the output
//  is not stalled; encoding gives four results per three items. The job of
//  the closing item is registered in the job queue, and its first result is
//  then registered in the output register. Reset clears the mode, the
//  group and the queue. Output stall holds the output register, the queue
//  then fills and stalls the input.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit import b64sc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       stream_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_final_o,
  output logic       bad_input_o
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  job_t      job;
  job_t      head;

  b64sc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .stream_end_i (stream_end_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .job_o        (job)
  );

  b64sc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  b64sc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_final_o (out_final_o),
    .bad_input_o (bad_input_o)
  );

endmodule

### rtl/b64sc_checker.sv
// ----------------------------------------------------------------------------
// b64sc_checker
// Port-level checks of the Base64 stream codec.
// ----------------------------------------------------------------------------
module b64sc_checker import b64sc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       cfg_data_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_final_o,
  input logic       bad_input_o
);

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(out_final_o) && $stable(bad_input_o))
    else $error("output changed under stall");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_input_o |-> out_byte_o == 8'h00)
    else $error("error result carries data");

  a_enc_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_q |-> !bad_input_o)
    else $error("error flag while encoding");

  a_enc_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_q |->
    (char_code(out_byte_o) != CODE_BAD))
    else $error("encoder emitted non-alphabet character");

endmodule

bind base64_stream_codec_unit b64sc_checker u_b64sc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_data_i  (cfg_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .out_final_o (out_final_o),
  .bad_input_o (bad_input_o)
);
